// ----- rtl/frbbs_pkg.sv -----
// Shared types, codes and constants of the buddy block splitter.
package frbbs_pkg;

    // Default sizing
    localparam int FRAMES_DEF    = 4096;
    localparam int MAX_ORDER_DEF = 6;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 12;
    localparam int ZONE_W   = 2;
    localparam int SEG_W    = 8;
    localparam int ORDER_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FIRST_W  = 12;
    localparam int LAST_W   = 12;
    localparam int LIMIT_W  = 13;

    // Frame entry layout
    localparam int ENTRY_W = 12;
    localparam int KEY_W   = ZONE_W + SEG_W;
    localparam int USE_BIT = 10;
    localparam int GRP_BIT = 11;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REWIND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NEXT   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [FIRST_W-1:0] WALK_FIRST_RST = 12'd0;
    localparam logic [LAST_W-1:0]  WALK_LAST_RST  = 12'd4095;
    localparam logic [LIMIT_W-1:0] RUN_LIMIT_RST  = 13'd4096;

    // Read address select
    localparam logic [1:0] RD_CURSOR      = 2'd0;
    localparam logic [1:0] RD_CURSOR_NEXT = 2'd1;
    localparam logic [1:0] RD_RUN_NEXT    = 2'd2;

    typedef struct packed {
        logic       load_wr;
        logic       rewind;
        logic       skip_step;
        logic       head_take;
        logic       run_step;
        logic       calc_order;
        logic       finish_block;
        logic       finish_done;
        logic [1:0] rd_sel;
    } cmd_t;

    typedef struct packed {
        logic cur_in_range;
        logic next_in_range;
        logic cur_busy;
        logic head_pass;
        logic run_pass;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/frbbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module frbbs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/frbbs_ctrl.sv -----
// Sequencing state machine of the buddy block splitter.
module frbbs_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [frbbs_pkg::ACTION_W-1:0] action,
    input  frbbs_pkg::stat_t               stat,
    output frbbs_pkg::cmd_t                cmd
);
    import frbbs_pkg::*;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SKIP_ISSUE = 3'd1;
    localparam logic [2:0] ST_SKIP_TEST  = 3'd2;
    localparam logic [2:0] ST_RUN_TEST   = 3'd3;
    localparam logic [2:0] ST_ORDER      = 3'd4;
    localparam logic [2:0] ST_FINISH     = 3'd5;
    localparam logic [2:0] ST_DONE       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CURSOR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_LOAD:   cmd.load_wr = 1'b1;
                        ACT_REWIND: cmd.rewind  = 1'b1;
                        ACT_NEXT:   state_next  = ST_SKIP_ISSUE;
                        default:    ;
                    endcase
                end
            end
            ST_SKIP_ISSUE:
            begin
                cmd.rd_sel = RD_CURSOR;
                state_next = stat.cur_in_range ? ST_SKIP_TEST : ST_DONE;
            end
            ST_SKIP_TEST:
            begin
                cmd.rd_sel = RD_CURSOR_NEXT;
                if (stat.cur_busy)
                begin
                    cmd.skip_step = 1'b1;
                    if (!stat.next_in_range)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.head_take = 1'b1;
                    state_next    = stat.head_pass ? ST_RUN_TEST : ST_ORDER;
                end
            end
            ST_RUN_TEST:
            begin
                cmd.rd_sel = RD_RUN_NEXT;
                if (stat.run_pass)
                begin
                    cmd.run_step = 1'b1;
                end
                else
                begin
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER:
            begin
                cmd.calc_order = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_block = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_done = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/frbbs_dp.sv -----
// Datapath: frame table, walk cursor, run counter, order pick and result register.
module frbbs_dp #(
    parameter int FRAMES    = frbbs_pkg::FRAMES_DEF,
    parameter int MAX_ORDER = frbbs_pkg::MAX_ORDER_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  frbbs_pkg::cmd_t                  cmd,
    output frbbs_pkg::stat_t                 stat,
    input  logic                             cfg_wr_en,
    input  logic [frbbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frbbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [frbbs_pkg::INDEX_W-1:0]    frame_index,
    input  logic [frbbs_pkg::ZONE_W-1:0]     frame_zone,
    input  logic [frbbs_pkg::SEG_W-1:0]      frame_segment,
    input  logic                             frame_in_use,
    input  logic                             frame_grouped,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             block_found,
    output logic [frbbs_pkg::INDEX_W-1:0]    block_start,
    output logic [frbbs_pkg::ORDER_W-1:0]    block_order,
    output logic                             walk_done
);
    import frbbs_pkg::*;

    localparam int AW    = $clog2(FRAMES);
    localparam int CW_RQ = $clog2(FRAMES + (1 << MAX_ORDER)) + 1;
    localparam int CW    = (CW_RQ > LIMIT_W) ? CW_RQ : LIMIT_W;
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam logic [CW-1:0] FRAMES_C  = CW'(FRAMES);
    localparam logic [CW-1:0] RUN_MAX_C = CW'(1) << MAX_ORDER;

    // Configuration
    logic [FIRST_W-1:0] walk_first_reg;
    logic [LAST_W-1:0]  walk_last_reg;
    logic [LIMIT_W-1:0] run_limit_reg;
    logic [CW-1:0]      walk_last_c;
    logic [CW-1:0]      run_limit_c;

    // Walk state
    logic [CW-1:0]      cursor_reg, cursor_next;
    logic [CW-1:0]      p_reg, p_next;
    logic [CW-1:0]      head_reg, head_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [ENTRY_W-1:0] head_data_reg, head_data_next;
    logic [OW-1:0]      order_reg, order_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic [INDEX_W-1:0] start_reg, start_next;
    logic [ORDER_W-1:0] bord_reg, bord_next;
    logic               done_reg, done_next;

    // Memory ports
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic [CW-1:0]      cursor_inc;
    logic [CW-1:0]      p_inc;
    logic [CW-1:0]      run_count;
    logic [OW-1:0]      order_pick;
    logic               load_ok;
    logic               out_free;

    assign walk_last_c = CW'(walk_last_reg);
    assign run_limit_c = CW'(run_limit_reg);
    assign cursor_inc  = cursor_reg + CW'(1);
    assign p_inc       = p_reg + CW'(1);
    assign run_count   = p_reg - head_reg;
    assign load_ok     = (32'(frame_index) < FRAMES);
    assign out_free    = !out_valid_reg || !out_stall;

    // Status to the controller
    always_comb
    begin
        stat.cur_in_range  = (cursor_reg <= walk_last_c) && (cursor_reg < FRAMES_C);
        stat.next_in_range = (cursor_inc <= walk_last_c) && (cursor_inc < FRAMES_C);
        stat.cur_busy      = rd_data[USE_BIT] || rd_data[GRP_BIT];
        stat.head_pass     = (cursor_reg < run_limit_c);
        stat.run_pass      = (p_reg < head_reg + RUN_MAX_C) && (p_reg <= walk_last_c)
                             && (p_reg < run_limit_c) && (p_reg < FRAMES_C)
                             && (rd_data[KEY_W-1:0] == key_reg) && !rd_data[USE_BIT];
        stat.out_free      = out_free;
    end

    // Largest order that fits the run and the head alignment
    always_comb
    begin
        order_pick = '0;
        for (int k = 1; k <= MAX_ORDER; k++)
        begin
            if ((run_count >= (CW'(1) << k))
                && ((head_reg & ((CW'(1) << k) - CW'(1))) == '0))
            begin
                order_pick = OW'(k);
            end
        end
    end

    // Read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CURSOR:      rd_addr = cursor_reg[AW-1:0];
            RD_CURSOR_NEXT: rd_addr = cursor_inc[AW-1:0];
            RD_RUN_NEXT:    rd_addr = p_inc[AW-1:0];
            default:        rd_addr = cursor_reg[AW-1:0];
        endcase
    end

    // Write port: loads from idle, head marking at block finish
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = head_reg[AW-1:0];
        wr_data = head_data_reg;
        if (cmd.load_wr)
        begin
            wr_en   = load_ok;
            wr_addr = AW'(frame_index);
            wr_data = {frame_grouped, frame_in_use, frame_segment, frame_zone};
        end
        else if (cmd.finish_block)
        begin
            wr_en            = 1'b1;
            wr_data[USE_BIT] = 1'b1;
            if (order_reg != '0)
            begin
                wr_data[GRP_BIT] = 1'b1;
            end
        end
    end

    frbbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cursor_next    = cursor_reg;
        p_next         = p_reg;
        head_next      = head_reg;
        key_next       = key_reg;
        head_data_next = head_data_reg;
        order_next     = order_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        start_next     = start_reg;
        bord_next      = bord_reg;
        done_next      = done_reg;

        if (cmd.rewind)
        begin
            cursor_next = CW'(walk_first_reg);
        end
        if (cmd.skip_step)
        begin
            cursor_next = cursor_inc;
        end
        if (cmd.head_take)
        begin
            head_next      = cursor_reg;
            key_next       = rd_data[KEY_W-1:0];
            head_data_next = rd_data;
            p_next         = stat.head_pass ? cursor_inc : cursor_reg;
        end
        if (cmd.run_step)
        begin
            p_next = p_inc;
        end
        if (cmd.calc_order)
        begin
            order_next = order_pick;
        end
        if (cmd.finish_block)
        begin
            cursor_next    = head_reg + (CW'(1) << order_reg);
            out_valid_next = 1'b1;
            found_next     = 1'b1;
            start_next     = head_reg[INDEX_W-1:0];
            bord_next      = ORDER_W'(order_reg);
            done_next      = 1'b0;
        end
        if (cmd.finish_done)
        begin
            out_valid_next = 1'b1;
            found_next     = 1'b0;
            start_next     = '0;
            bord_next      = '0;
            done_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_first_reg <= WALK_FIRST_RST;
            walk_last_reg  <= WALK_LAST_RST;
            run_limit_reg  <= RUN_LIMIT_RST;
            cursor_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_WALK_FIRST: walk_first_reg <= cfg_data[FIRST_W-1:0];
                    CFG_WALK_LAST:  walk_last_reg  <= cfg_data[LAST_W-1:0];
                    CFG_RUN_LIMIT:  run_limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        head_reg      <= head_next;
        key_reg       <= key_next;
        head_data_reg <= head_data_next;
        order_reg     <= order_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
        bord_reg      <= bord_next;
        done_reg      <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign block_found = found_reg;
    assign block_start = start_reg;
    assign block_order = bord_reg;
    assign walk_done   = done_reg;

endmodule

// ----- rtl/free_run_buddy_block_splitter.sv -----
// Top level of the buddy block splitter: controller, datapath and checks.
//
//  Channel   Handshake               Carries
//  in        in_valid / in_stall     action, frame_index, frame_zone, frame_segment,
//                                    frame_in_use, frame_grouped
//  out       out_valid / out_stall   block_found, block_start, block_order, walk_done
//  cfg       cfg_wr_en               cfg_index, cfg_data (walk_first, walk_last, run_limit)
//
//  Load and rewind transactions leave the controller idle and never raise in_stall.
//  After a next is taken, in_stall stays high while it skips S busy frames and tests
//  the R frames of the free run (at most 2^MAX_ORDER, zero when the head is at or past
//  run_limit), one frame per cycle through the frame RAM's single read port, then picks
//  the order and posts the result; a next that finds the walk finished posts a done result.
//  Reset clears the cursor and the result valid flag, and sets the configuration to its
//  reset values; the frame RAM holds garbage until loaded and has no clearing pass.
//  A stalled result holds the output register; a next transaction waits for it to drain
//  before it posts, while loads and rewinds still go through.
module free_run_buddy_block_splitter #(
    parameter int FRAMES    = frbbs_pkg::FRAMES_DEF,
    parameter int MAX_ORDER = frbbs_pkg::MAX_ORDER_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input transactions
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [frbbs_pkg::ACTION_W-1:0]   action,
    input  logic [frbbs_pkg::INDEX_W-1:0]    frame_index,
    input  logic [frbbs_pkg::ZONE_W-1:0]     frame_zone,
    input  logic [frbbs_pkg::SEG_W-1:0]      frame_segment,
    input  logic                             frame_in_use,
    input  logic                             frame_grouped,
    // result transactions
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             block_found,
    output logic [frbbs_pkg::INDEX_W-1:0]    block_start,
    output logic [frbbs_pkg::ORDER_W-1:0]    block_order,
    output logic                             walk_done,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [frbbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frbbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import frbbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller walks skip, run test, order pick and finish
    frbbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath holds the frame table, cursor, run pointer and result register
    frbbs_dp #(
        .FRAMES    (FRAMES),
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frame_index   (frame_index),
        .frame_zone    (frame_zone),
        .frame_segment (frame_segment),
        .frame_in_use  (frame_in_use),
        .frame_grouped (frame_grouped),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .block_found   (block_found),
        .block_start   (block_start),
        .block_order   (block_order),
        .walk_done     (walk_done)
    );

    // A result is either a carved block or the end of the walk, never both
    a_found_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (block_found != walk_done))
        else $error("result marks both or neither of found and done");

    // A carved block starts on a boundary of its own size
    a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && block_found) |->
            ((block_start & ~(12'hFFF << block_order)) == 12'h000))
        else $error("carved block is not aligned to its order");

    // A result is never posted over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_block || cmd.finish_done) |-> (!out_valid || !out_stall))
        else $error("result posted over a stalled result");

    // Run and skip work never run while the input is open
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.skip_step || cmd.run_step || cmd.head_take) |-> in_stall)
        else $error("walk work while input is not stalled");

endmodule

// ----- verif/free_run_buddy_block_splitter_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the free-run buddy block splitter.
module free_run_buddy_block_splitter_test;
    import frbbs_pkg::*;

    localparam int FRAMES      = FRAMES_DEF;
    localparam int MAX_ORDER   = MAX_ORDER_DEF;
    localparam int RUN_MAX     = 1 << MAX_ORDER;
    // Frames loaded at the start; walks stay below this bound or in the top block.
    localparam int LOW_FRAMES  = 192;
    localparam int RANDOM_TXNS = 150;
    // A load may still be writing the RAM when the last result drains.
    localparam int SETTLE_PAD  = 8;
    localparam int END_PAD     = 100;

    // Action code that the block ignores.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [ACTION_W-1:0]   action;
    logic [INDEX_W-1:0]    frame_index;
    logic [ZONE_W-1:0]     frame_zone;
    logic [SEG_W-1:0]      frame_segment;
    logic                  frame_in_use;
    logic                  frame_grouped;
    logic                  out_valid;
    logic                  out_stall;
    logic                  block_found;
    logic [INDEX_W-1:0]    block_start;
    logic [ORDER_W-1:0]    block_order;
    logic                  walk_done;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // One reported block, as seen on the result channel.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] start;
        logic [ORDER_W-1:0] order;
        logic               done;
    } block_rpt_t;

    // Blocks predicted for next transactions, oldest first.
    block_rpt_t block_expect[$];

    // Shadow of the frame table, walk cursor and walk registers.
    logic [ENTRY_W-1:0] frame_tab [FRAMES];
    int walk_pos;
    int first_reg;
    int last_reg;
    int limit_reg;

    int err_count;
    int txn_count;      // transactions that the block acts on
    bit in_gaps_on;     // sender idles between transactions
    bit out_stalls_on;  // receiver stalls results

    free_run_buddy_block_splitter #(
        .FRAMES    (FRAMES),
        .MAX_ORDER (MAX_ORDER)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .frame_index   (frame_index),
        .frame_zone    (frame_zone),
        .frame_segment (frame_segment),
        .frame_in_use  (frame_in_use),
        .frame_grouped (frame_grouped),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .block_found   (block_found),
        .block_start   (block_start),
        .block_order   (block_order),
        .walk_done     (walk_done),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Block predictor
    // ------------------------------------------------------------------

    // Length of the free run at head: same zone and segment, not in use,
    // capped by the largest block, the walk end and the run limit.
    // A grouped frame does not end the run.
    function automatic int free_run_len(input int head);
        logic [KEY_W-1:0] key;
        int p;
        key = frame_tab[head][KEY_W-1:0];
        p = head;
        while (p < head + RUN_MAX && p <= last_reg && p < limit_reg && p < FRAMES)
        begin
            if (frame_tab[p][KEY_W-1:0] != key || frame_tab[p][USE_BIT])
                break;
            p++;
        end
        return p - head;
    endfunction

    // Largest order that fits the run and to which the head is aligned.
    function automatic int fit_order(input int head, input int count);
        for (int k = MAX_ORDER; k >= 1; k--)
        begin
            if (count >= (1 << k) && head % (1 << k) == 0)
                return k;
        end
        return 0;
    endfunction

    // Skip busy frames, then carve the next block or report the walk done.
    function automatic void carve_block(output block_rpt_t rpt);
        int head;
        int ord;
        rpt = '0;
        while (walk_pos <= last_reg && walk_pos < FRAMES
               && (frame_tab[walk_pos][USE_BIT] || frame_tab[walk_pos][GRP_BIT]))
            walk_pos++;
        if (walk_pos > last_reg || walk_pos >= FRAMES)
        begin
            // Cursor stays where it is.
            rpt.done = 1'b1;
            return;
        end
        head = walk_pos;
        ord = fit_order(head, free_run_len(head));
        frame_tab[head][USE_BIT] = 1'b1;
        if (ord >= 1)
            frame_tab[head][GRP_BIT] = 1'b1;
        walk_pos = head + (1 << ord);
        rpt.found = 1'b1;
        rpt.start = head[INDEX_W-1:0];
        rpt.order = ord[ORDER_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Idle cycles before a transaction: mostly none or short, a few long.
    function automatic int in_gap();
        int r;
        if (!in_gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Present one input transaction, wait for it to be taken, then update the
    // predictor. rpt carries the predicted block of a next transaction.
    task automatic send_txn(input logic [ACTION_W-1:0] act,
                            input logic [INDEX_W-1:0]  idx,
                            input logic [ZONE_W-1:0]   zn,
                            input logic [SEG_W-1:0]    sg,
                            input logic                in_use_f,
                            input logic                grp_f,
                            output block_rpt_t         rpt);
        int gap;
        gap = in_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        frame_index   <= idx;
        frame_zone    <= zn;
        frame_segment <= sg;
        frame_in_use  <= in_use_f;
        frame_grouped <= grp_f;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        rpt = '0;
        case (act)
            ACT_LOAD:   frame_tab[idx] = {grp_f, in_use_f, sg, zn};
            ACT_REWIND: walk_pos = first_reg;
            ACT_NEXT:
            begin
                carve_block(rpt);
                block_expect.push_back(rpt);
            end
            default: ;
        endcase
        if (act != ACT_UNUSED)
            txn_count++;
    endtask

    task automatic load_frame(input int idx, input logic [ZONE_W-1:0] zn,
                              input logic [SEG_W-1:0] sg, input logic in_use_f,
                              input logic grp_f);
        block_rpt_t unused_rpt;
        send_txn(ACT_LOAD, idx[INDEX_W-1:0], zn, sg, in_use_f, grp_f, unused_rpt);
    endtask

    // Fields other than the action carry noise on rewind and next.
    task automatic rewind_walk();
        block_rpt_t unused_rpt;
        send_txn(ACT_REWIND, INDEX_W'($urandom), ZONE_W'($urandom), SEG_W'($urandom),
                 1'($urandom), 1'($urandom), unused_rpt);
    endtask

    task automatic next_block(output block_rpt_t rpt);
        send_txn(ACT_NEXT, INDEX_W'($urandom), ZONE_W'($urandom), SEG_W'($urandom),
                 1'($urandom), 1'($urandom), rpt);
    endtask

    // Stop sending and wait until every predicted block has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (block_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WALK_FIRST: first_reg = val & ((1 << FIRST_W) - 1);
            CFG_WALK_LAST:  last_reg  = val & ((1 << LAST_W) - 1);
            CFG_RUN_LIMIT:  limit_reg = val & ((1 << LIMIT_W) - 1);
            default: ;
        endcase
    endtask

    // Registers change only with the block idle.
    task automatic set_walk(input int first, input int last, input int limit);
        drain_results();
        repeat (SETTLE_PAD) @(posedge clk);
        write_reg(CFG_WALK_FIRST, first);
        write_reg(CFG_WALK_LAST, last);
        write_reg(CFG_RUN_LIMIT, limit);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Stall runs: mostly short, a few long; off when out_stalls_on is low.
    initial
    begin : stall_gen
        int stall_left;
        logic stall_level;
        out_stall = 1'b0;
        stall_left = 0;
        stall_level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (out_stalls_on && $urandom_range(0, 2) == 0)
                begin
                    stall_level = 1'b1;
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                           : $urandom_range(4, 25);
                end
                else
                begin
                    stall_level = 1'b0;
                    stall_left = $urandom_range(1, 6);
                end
            end
            out_stall <= stall_level;
            stall_left--;
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Every result transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_result
        block_rpt_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (block_expect.size() == 0)
            begin
                $display("%0t: unexpected result: found %0b start %0d order %0d done %0b",
                         $time, block_found, block_start, block_order, walk_done);
                err_count++;
            end
            else
            begin
                want = block_expect.pop_front();
                check_field("block_found", 16'(want.found), 16'(block_found));
                check_field("block_start", 16'(want.start), 16'(block_start));
                check_field("block_order", 16'(want.order), 16'(block_order));
                check_field("walk_done", 16'(want.done), 16'(walk_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load the low frames and the top block once; every walk stays inside
    // them, so no walk ever reads an unwritten entry.
    //   0..63     one key, free; frame 5 grouped but free (does not end a run)
    //   64..79    same key; 64 in use, 65 grouped, so the walk skips both
    //   80..127   a second key, free
    //   128..191  zone changes every frame; every eighth frame in use
    //   top 64    one key, free, aligned for a full-size block at the end
    task automatic test_table_load();
        logic [ZONE_W-1:0] zn;
        logic [SEG_W-1:0] sg;
        logic u;
        logic g;
        for (int i = 0; i < LOW_FRAMES; i++)
        begin
            u = 1'b0;
            g = 1'b0;
            if (i < 80)
            begin
                zn = 2'd1;
                sg = 8'h11;
                u = (i == 64);
                g = (i == 5) || (i == 65);
            end
            else if (i < 128)
            begin
                zn = 2'd2;
                sg = 8'hEE;
            end
            else
            begin
                zn = i[1:0];
                sg = 8'h5A;
                u = (i % 8 == 7);
            end
            load_frame(i, zn, sg, u, g);
        end
        for (int i = FRAMES - RUN_MAX; i < FRAMES; i++)
            load_frame(i, 2'd3, 8'hFF, 1'b0, 1'b0);
    endtask

    // Reset settings: orders 6, 1, 2, 3, 4, 5 in turn, then a single frame.
    task automatic test_block_orders();
        block_rpt_t rpt;
        rewind_walk();
        repeat (3) next_block(rpt);
        // Sender holds off until the block has caught up.
        drain_results();
        repeat (4) next_block(rpt);
    endtask

    // Full-size block at the top, then the cursor sits at the table end.
    task automatic test_walk_end();
        block_rpt_t rpt;
        set_walk(FRAMES - RUN_MAX, FRAMES - 1, FRAMES);
        rewind_walk();
        next_block(rpt);
        next_block(rpt);
    endtask

    // Run limit below the head: every block is a single frame.
    task automatic test_empty_run();
        block_rpt_t rpt;
        set_walk(130, LOW_FRAMES - 1, 0);
        rewind_walk();
        next_block(rpt);
        next_block(rpt);
    endtask

    // walk_last cuts the run short; a walk that starts beyond its end.
    task automatic test_walk_bounds();
        block_rpt_t rpt;
        set_walk(8, 11, FRAMES - 1);
        rewind_walk();
        next_block(rpt);
        next_block(rpt);
        set_walk(FRAMES - 1, 0, FRAMES);
        rewind_walk();
        next_block(rpt);
    endtask

    // Ignored action, loads with all-ones and all-zeros fields.
    task automatic test_odd_items();
        block_rpt_t rpt;
        send_txn(ACT_UNUSED, INDEX_W'($urandom), ZONE_W'($urandom), SEG_W'($urandom),
                 1'($urandom), 1'($urandom), rpt);
        load_frame(FRAMES - 1, 2'd3, 8'hFF, 1'b1, 1'b1);
        load_frame(0, 2'd0, 8'h00, 1'b0, 1'b0);
        set_walk(0, 7, FRAMES);
        rewind_walk();
        next_block(rpt);
    endtask

    // Phases of random walk settings inside the low frames. Most episodes
    // free a run of frames, rewind and walk it; the rest are bare walks or
    // random noise.
    task automatic test_random_walks();
        int start_count;
        int first;
        int last;
        int limit;
        int pick;
        int base;
        int len;
        int steps;
        logic [ZONE_W-1:0] zn;
        logic [SEG_W-1:0] sg;
        block_rpt_t rpt;
        start_count = txn_count;
        while (txn_count - start_count < RANDOM_TXNS)
        begin
            pick = $urandom_range(0, 9);
            first = $urandom_range(0, LOW_FRAMES - 1);
            if (pick < 7)
                last = first + $urandom_range(8, 300);
            else if (pick == 7)
                last = first + $urandom_range(0, 7);
            else if (pick == 8)
            begin
                first = $urandom_range(1, FRAMES - 1);
                last = first - $urandom_range(1, first);
            end
            else
            begin
                first = $urandom_range(0, RUN_MAX - 1);
                last = LOW_FRAMES - 1;
            end
            if (last > LOW_FRAMES - 1)
                last = LOW_FRAMES - 1;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                limit = FRAMES;
            else if (pick < 8)
                limit = $urandom_range(first, (last + RUN_MAX > FRAMES) ? FRAMES
                                                                      : last + RUN_MAX);
            else if (pick == 8)
                limit = $urandom_range(0, first);
            else
                limit = FRAMES - 1;
            set_walk(first, last, limit);
            // Some phases run without any idling on one side or both.
            in_gaps_on = ($urandom_range(0, 4) != 0);
            out_stalls_on = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(3, 6))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    base = $urandom_range(first, last);
                    base = base & ~((1 << $urandom_range(0, MAX_ORDER)) - 1);
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, RUN_MAX + 8)
                                                      : $urandom_range(1, 16);
                    zn = ZONE_W'($urandom);
                    sg = SEG_W'($urandom);
                    for (int j = 0; j < len && base + j < FRAMES; j++)
                        load_frame(base + j, zn, sg, $urandom_range(0, 11) == 0,
                                   $urandom_range(0, 11) == 0);
                    if ($urandom_range(0, 6) != 0)
                        rewind_walk();
                    steps = $urandom_range(1, 12);
                    for (int j = 0; j < steps; j++)
                    begin
                        next_block(rpt);
                        if (rpt.done && $urandom_range(0, 2) != 0)
                            break;
                    end
                end
                else if (pick < 8)
                begin
                    if ($urandom_range(0, 1) == 0)
                        rewind_walk();
                    repeat ($urandom_range(1, 4)) next_block(rpt);
                end
                else
                begin
                    repeat ($urandom_range(2, 8))
                        send_txn(ACTION_W'($urandom_range(0, 3)), INDEX_W'($urandom),
                                 ZONE_W'($urandom), SEG_W'($urandom),
                                 1'($urandom), 1'($urandom), rpt);
                end
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
        end
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_LOAD;
        frame_index   = '0;
        frame_zone    = '0;
        frame_segment = '0;
        frame_in_use  = 1'b0;
        frame_grouped = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_WALK_FIRST;
        cfg_data      = '0;
        walk_pos      = 0;
        first_reg     = int'(WALK_FIRST_RST);
        last_reg      = int'(WALK_LAST_RST);
        limit_reg     = int'(RUN_LIMIT_RST);
        err_count     = 0;
        txn_count     = 0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_block_orders();
        test_walk_end();
        test_empty_run();
        test_walk_bounds();
        test_odd_items();
        test_random_walks();

        drain_results();
        repeat (END_PAD) @(posedge clk);
        if (err_count == 0)
            $display("[free_run_buddy_block_splitter] OK");
        else
            $display("[free_run_buddy_block_splitter] ERROR");
        $finish;
    end

    // Hang guard, well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("[free_run_buddy_block_splitter] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/frbbs_pkg.sv
rtl/frbbs_ram.sv
rtl/frbbs_ctrl.sv
rtl/frbbs_dp.sv
rtl/free_run_buddy_block_splitter.sv
verif/free_run_buddy_block_splitter_test.sv
